[design/dcs_pkg.sv]
// Shared constants, types and width helpers for the distance constraint solver.
// Used by every module of the block; depends on nothing else.
package dcs_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int STIFF_W       = 17;
  localparam int FRAC_W        = 16;
  localparam int QUEUE_DEPTH   = 4;

  // Classification that the front attaches to every link.
  typedef struct packed {
    logic degenerate;
    logic first_pinned;
    logic second_pinned;
  } link_class_t;

  localparam int CLASS_W = $bits(link_class_t);

  // Width of one queued link: four positions, two deltas of one extra bit,
  // the rest length, the stiffness and the class.
  function automatic int link_width(input int pos_w);
    return 7 * pos_w + 1 + STIFF_W + CLASS_W;
  endfunction

endpackage

[design/dcs_front.sv]
// Front end of the solver: accepts links, forms the endpoint deltas and classifies them.
// Depends on dcs_pkg.
module dcs_front import dcs_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int LW = link_width(POS_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        link_valid,
  output logic                        link_ready,
  input  logic signed [POS_WIDTH-1:0] first_x,
  input  logic signed [POS_WIDTH-1:0] first_y,
  input  logic signed [POS_WIDTH-1:0] second_x,
  input  logic signed [POS_WIDTH-1:0] second_y,
  input  logic                        first_pinned,
  input  logic                        second_pinned,
  input  logic [POS_WIDTH-2:0]        rest_length,
  input  logic [STIFF_W-1:0]          stiffness,
  output logic                        item_valid,
  input  logic                        item_ready,
  output logic [LW-1:0]               item
);

  localparam int P = POS_WIDTH;

  logic          f_v;
  logic [LW-1:0] f_item;
  logic [P:0]    dx;
  logic [P:0]    dy;
  link_class_t   cls;

  assign dx = (P+1)'(second_x) - (P+1)'(first_x);
  assign dy = (P+1)'(second_y) - (P+1)'(first_y);

  always_comb begin
    cls.degenerate    = (first_x == second_x) && (first_y == second_y);
    cls.first_pinned  = first_pinned;
    cls.second_pinned = second_pinned;
  end

  assign link_ready = !f_v || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (link_ready) begin
      f_v <= link_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (link_ready && link_valid) begin
      f_item <= {cls, stiffness, rest_length, dy, dx, second_y, second_x, first_y, first_x};
    end
  end

  assign item_valid = f_v;
  assign item       = f_item;

endmodule

[design/dcs_queue.sv]
// Short first-in first-out queue that decouples the front from the arithmetic back end.
// Depends on dcs_pkg for the default depth.
module dcs_queue import dcs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[design/dcs_back.sv]
// Arithmetic back end: squares, pipelined square root, correction product,
// pipelined rounding divider and saturating update. Depends on dcs_pkg.
module dcs_back import dcs_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int LW = link_width(POS_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [LW-1:0]        item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [POS_WIDTH-1:0] new_first_x,
  output logic [POS_WIDTH-1:0] new_first_y,
  output logic [POS_WIDTH-1:0] new_second_x,
  output logic [POS_WIDTH-1:0] new_second_y,
  output logic                 degenerate
);

  localparam int P    = POS_WIDTH;
  localparam int MW   = P + 1;               // delta magnitude
  localparam int SW   = 2 * P + 2;           // sum of squares
  localparam int RW   = P + 1;               // link length
  localparam int VW   = P + 2;               // deviation
  localparam int DSW  = VW + STIFF_W;        // |dev| * stiffness
  localparam int NW   = MW + DSW;            // numerator
  localparam int QW   = P + 3;               // quotient
  localparam int DENW = RW + FRAC_W + 1;     // denominator
  localparam int LO   = (MW + 1) / 2;
  localparam int HI   = MW - LO;
  localparam int CRW  = QW + 2;              // signed correction
  localparam int SUMW = QW + 3;              // position plus correction
  localparam int PW   = 4 * P + CLASS_W;
  localparam int SDW  = (P - 1) + STIFF_W + 2 + 2 * MW + PW;

  function automatic logic [P-1:0] sat_pos(input logic [SUMW-1:0] v);
    if (&v[SUMW-1:P-1] || ~|v[SUMW-1:P-1]) begin
      sat_pos = v[P-1:0];
    end else if (v[SUMW-1]) begin
      sat_pos = {1'b1, {(P-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(P-1){1'b1}}};
    end
  endfunction

  // The whole back end advances together whenever the output register can move.
  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // Unpack the queued link.
  logic [P-1:0]       i_x1, i_y1, i_x2, i_y2;
  logic [P:0]         i_dx, i_dy;
  logic [P-2:0]       i_rest;
  logic [STIFF_W-1:0] i_stiff;
  link_class_t        i_cls;
  logic [MW-1:0]      i_mx, i_my;

  assign {i_cls, i_stiff, i_rest, i_dy, i_dx, i_y2, i_x2, i_y1, i_x1} = item;
  assign i_mx = i_dx[P] ? MW'(0) - i_dx : i_dx;
  assign i_my = i_dy[P] ? MW'(0) - i_dy : i_dy;

  // Squares of the delta magnitudes.
  logic           a_v;
  logic [SW-1:0]  a_sqx, a_sqy;
  logic [SDW-1:0] a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sqx  <= SW'(i_mx) * SW'(i_mx);
      a_sqy  <= SW'(i_my) * SW'(i_my);
      a_side <= {i_rest, i_stiff, i_dy[P], i_dx[P], i_my, i_mx,
                 i_cls, i_x1, i_y1, i_x2, i_y2};
    end
  end

  // Square root, one result bit per stage.
  logic           sq_v    [RW+1];
  logic [SW-1:0]  sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];
  logic [SDW-1:0] sq_side [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= a_sqx + a_sqy;
      sq_root[0] <= '0;
      sq_side[0] <= a_side;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [SW:0] trial;
    logic        ge;

    assign trial = ((SW+1)'(sq_root[k]) << (B + 1)) + ((SW+1)'(1) << (2 * B));
    assign ge    = (SW+1)'(sq_rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1]  <= ge ? sq_rem[k] - trial[SW-1:0] : sq_rem[k];
        sq_root[k+1] <= ge ? (sq_root[k] | (RW'(1) << B)) : sq_root[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Deviation from rest length and the denominator.
  logic [P-2:0]       s_rest;
  logic [STIFF_W-1:0] s_stiff;
  logic               s_negx, s_negy;
  logic [MW-1:0]      s_mx, s_my;
  logic [PW-1:0]      s_pass;
  link_class_t        s_cls;
  logic [RW-1:0]      len;
  logic [VW-1:0]      dev;
  logic [VW-1:0]      mdev;

  assign {s_rest, s_stiff, s_negy, s_negx, s_my, s_mx, s_pass} = sq_side[RW];
  assign s_cls = link_class_t'(s_pass[PW-1 -: CLASS_W]);
  assign len   = sq_root[RW];
  assign dev   = VW'(len) - VW'(s_rest);
  assign mdev  = dev[VW-1] ? VW'(0) - dev : dev;

  logic               c_v;
  logic [VW-1:0]      c_mdev;
  logic               c_neg [2];
  logic [DENW-1:0]    c_den;
  logic [STIFF_W-1:0] c_stiff;
  logic [MW-1:0]      c_m   [2];
  logic [PW-1:0]      c_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= sq_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mdev   <= mdev;
      c_neg[0] <= s_negx ^ dev[VW-1];
      c_neg[1] <= s_negy ^ dev[VW-1];
      // Both endpoints free: each takes half, so the denominator doubles.
      c_den    <= (!s_cls.first_pinned && !s_cls.second_pinned) ?
                  (DENW'(len) << (FRAC_W + 1)) : (DENW'(len) << FRAC_W);
      c_stiff  <= s_stiff;
      c_m[0]   <= s_mx;
      c_m[1]   <= s_my;
      c_pass   <= s_pass;
    end
  end

  // |dev| times stiffness.
  logic            d_v;
  logic [DSW-1:0]  d_ds;
  logic            d_neg [2];
  logic [DENW-1:0] d_den;
  logic [MW-1:0]   d_m   [2];
  logic [PW-1:0]   d_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ds   <= DSW'(c_mdev) * DSW'(c_stiff);
      d_neg  <= c_neg;
      d_den  <= c_den;
      d_m    <= c_m;
      d_pass <= c_pass;
    end
  end

  // Numerator in two partial products per lane, then their sum.
  logic              e_v;
  logic [LO+DSW-1:0] e_pl  [2];
  logic [HI+DSW-1:0] e_ph  [2];
  logic              e_neg [2];
  logic [DENW-1:0]   e_den;
  logic [PW-1:0]     e_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        e_pl[l] <= (LO+DSW)'(d_m[l][LO-1:0]) * (LO+DSW)'(d_ds);
        e_ph[l] <= (HI+DSW)'(d_m[l][MW-1:LO]) * (HI+DSW)'(d_ds);
      end
      e_neg  <= d_neg;
      e_den  <= d_den;
      e_pass <= d_pass;
    end
  end

  // Restoring divider, one quotient bit per stage, x and y side by side.
  logic            dv_v    [QW+1];
  logic [DENW-1:0] dv_rem  [QW+1][2];
  logic [QW-1:0]   dv_low  [QW+1][2];
  logic [QW-1:0]   dv_q    [QW+1][2];
  logic            dv_neg  [QW+1][2];
  logic [DENW-1:0] dv_den  [QW+1];
  logic [PW-1:0]   dv_pass [QW+1];
  logic [NW-1:0]   num     [2];

  for (genvar l = 0; l < 2; l++) begin : g_num
    assign num[l] = NW'(e_pl[l]) + (NW'(e_ph[l]) << LO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        dv_rem[0][l] <= DENW'(num[l][NW-1:QW]);
        dv_low[0][l] <= num[l][QW-1:0];
        dv_q[0][l]   <= '0;
      end
      dv_neg[0]  <= e_neg;
      dv_den[0]  <= e_den;
      dv_pass[0] <= e_pass;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DENW:0] r2;
      logic [DENW:0] diff;
      logic          ge;

      assign r2   = {dv_rem[k][l], dv_low[k][l][B]};
      assign diff = r2 - {1'b0, dv_den[k]};
      assign ge   = r2 >= {1'b0, dv_den[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1][l] <= ge ? diff[DENW-1:0] : r2[DENW-1:0];
          dv_low[k+1][l] <= dv_low[k][l];
          dv_q[k+1][l]   <= dv_q[k][l] | (QW'(ge) << B);
          dv_neg[k+1][l] <= dv_neg[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[k+1]  <= dv_den[k];
        dv_pass[k+1] <= dv_pass[k];
      end
    end
  end

  // Round to nearest, ties away from zero, and apply the sign.
  logic                  g_v;
  logic signed [CRW-1:0] g_c [2];
  logic [PW-1:0]         g_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= dv_v[QW];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_round
    logic          up;
    logic [QW:0]   cmag;

    assign up   = {dv_rem[QW][l], 1'b0} >= {1'b0, dv_den[QW]};
    assign cmag = (QW+1)'(dv_q[QW][l]) + (QW+1)'(up);

    always_ff @(posedge clk) begin
      if (en) begin
        g_c[l] <= dv_neg[QW][l] ? CRW'(0) - CRW'(cmag) : CRW'(cmag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_pass <= dv_pass[QW];
    end
  end

  // Saturating position update into the output register.
  link_class_t            o_cls;
  logic signed [P-1:0]    o_x1, o_y1, o_x2, o_y2;
  logic                   hold1, hold2;
  logic [SUMW-1:0]        sum_x1, sum_y1, sum_x2, sum_y2;

  assign {o_cls, o_x1, o_y1, o_x2, o_y2} = g_pass;
  assign hold1  = o_cls.degenerate || o_cls.first_pinned;
  assign hold2  = o_cls.degenerate || o_cls.second_pinned;
  assign sum_x1 = SUMW'(o_x1) + SUMW'(g_c[0]);
  assign sum_y1 = SUMW'(o_y1) + SUMW'(g_c[1]);
  assign sum_x2 = SUMW'(o_x2) - SUMW'(g_c[0]);
  assign sum_y2 = SUMW'(o_y2) - SUMW'(g_c[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // With both ends pinned, hold1 and hold2 both pass the positions through.
      new_first_x  <= hold1 ? o_x1 : sat_pos(sum_x1);
      new_first_y  <= hold1 ? o_y1 : sat_pos(sum_y1);
      new_second_x <= hold2 ? o_x2 : sat_pos(sum_x2);
      new_second_y <= hold2 ? o_y2 : sat_pos(sum_y2);
      degenerate   <= o_cls.degenerate;
    end
  end

endmodule

[design/distance_constraint_solve_unit.sv]
// Top level of the distance constraint solver: front, link queue and back end.
// Depends on dcs_pkg, dcs_front, dcs_queue and dcs_back.
//
// Usage notes.
// The block solves one distance constraint of a Verlet link per item. A link
// enters on the link channel (link_valid / link_ready) with both endpoints in
// signed Q16.16, two pinned flags, a rest length and a Q1.16 stiffness. The
// corrected endpoints leave on the result channel (result_valid /
// result_ready), one result item per link, in order, with the degenerate flag
// set when both endpoints coincide (positions then pass unchanged).
// Throughput is one link per cycle while the output is not stalled. The square
// root and the rounding divider each resolve one bit per pipeline stage.
// The front register accepts a link and hands it to a four-entry queue, so
// link_ready stays high while the back end is stalled until the queue and the
// front register are full. When result_valid is high and result_ready is low,
// the whole back end holds its contents and the waiting result stays on the
// output ports unchanged. A synchronous reset empties the front register, the
// queue and every pipeline stage; link_ready is high in the first cycle after
// reset.
module distance_constraint_solve_unit import dcs_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        link_valid,
  output logic                        link_ready,
  input  logic signed [POS_WIDTH-1:0] first_x,
  input  logic signed [POS_WIDTH-1:0] first_y,
  input  logic signed [POS_WIDTH-1:0] second_x,
  input  logic signed [POS_WIDTH-1:0] second_y,
  input  logic                        first_pinned,
  input  logic                        second_pinned,
  input  logic [POS_WIDTH-2:0]        rest_length,
  input  logic [STIFF_W-1:0]          stiffness,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [POS_WIDTH-1:0] new_first_x,
  output logic signed [POS_WIDTH-1:0] new_first_y,
  output logic signed [POS_WIDTH-1:0] new_second_x,
  output logic signed [POS_WIDTH-1:0] new_second_y,
  output logic                        degenerate
);

  localparam int LW = link_width(POS_WIDTH);

  // Front to queue.
  logic          fq_valid;
  logic          fq_ready;
  logic [LW-1:0] fq_item;

  // Queue to back end.
  logic          qb_valid;
  logic          qb_ready;
  logic [LW-1:0] qb_item;

  dcs_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .link_valid   (link_valid),
    .link_ready   (link_ready),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_x     (second_x),
    .second_y     (second_y),
    .first_pinned (first_pinned),
    .second_pinned(second_pinned),
    .rest_length  (rest_length),
    .stiffness    (stiffness),
    .item_valid   (fq_valid),
    .item_ready   (fq_ready),
    .item         (fq_item)
  );

  // The queue lets the front keep taking links while the back end is stalled.
  dcs_queue #(
    .WIDTH(LW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_item),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_item)
  );

  dcs_back #(
    .POS_WIDTH(POS_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (qb_valid),
    .item_ready  (qb_ready),
    .item        (qb_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .new_first_x (new_first_x),
    .new_first_y (new_first_y),
    .new_second_x(new_second_x),
    .new_second_y(new_second_y),
    .degenerate  (degenerate)
  );

endmodule

[design/dcs_checker.sv]
// Port-level checks for the distance constraint solver and the bind that attaches them.
// Depends on dcs_pkg and the top level distance_constraint_solve_unit.
module dcs_checker import dcs_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 link_valid,
  input logic                 link_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [POS_WIDTH-1:0] new_first_x,
  input logic [POS_WIDTH-1:0] new_first_y,
  input logic [POS_WIDTH-1:0] new_second_x,
  input logic [POS_WIDTH-1:0] new_second_y,
  input logic                 degenerate
);

  // Items accepted but not yet delivered.
  logic [7:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 8'(link_valid && link_ready) - 8'(result_valid && result_ready);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid && link_ready)
    else $error("block not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> inflight != '0)
    else $error("result without an outstanding item");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(new_first_x) && $stable(new_first_y) &&
      $stable(new_second_x) && $stable(new_second_y) && $stable(degenerate))
    else $error("result payload changed while stalled");

endmodule

bind distance_constraint_solve_unit dcs_checker #(.POS_WIDTH(POS_WIDTH)) u_dcs_checker (.*);
